// ----- rtl/core/cbc_pkg.sv -----
package cbc_pkg;

    localparam int ADDR_W     = 15;
    localparam int DATA_W     = 8;
    localparam int ROM_BANK_W = 9;
    localparam int RAM_BANK_W = 4;
    localparam int CLK_SEL_W  = 4;
    localparam int RAM_SIZE_W = 18;
    localparam int CFG_DATA_W = 18;

    // Configuration register indexes
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_CART_KIND     = 2'd0;
    localparam cfg_index_t CFG_ROM_SIZE_CODE = 2'd1;
    localparam cfg_index_t CFG_RAM_SIZE      = 2'd2;
    localparam cfg_index_t CFG_RUMBLE_EN     = 2'd3;

    // Cartridge type codes
    localparam logic [7:0] KIND_MBC1_FIRST = 8'h01;
    localparam logic [7:0] KIND_MBC1_LAST  = 8'h03;
    localparam logic [7:0] KIND_MBC2_A     = 8'h05;
    localparam logic [7:0] KIND_MBC2_B     = 8'h06;
    localparam logic [7:0] KIND_MBC3_A     = 8'h10;
    localparam logic [7:0] KIND_MBC3_B     = 8'h13;
    localparam logic [7:0] KIND_MBC5_FIRST = 8'h19;
    localparam logic [7:0] KIND_MBC5_LAST  = 8'h1E;

    // Control area split into 8 KB regions by address bits 14:13
    typedef logic [1:0] region_t;
    localparam region_t REGION_RAM_EN   = 2'd0;
    localparam region_t REGION_ROM_BANK = 2'd1;
    localparam region_t REGION_RAM_BANK = 2'd2;
    localparam region_t REGION_MODE     = 2'd3;

    // Data codes
    localparam logic [7:0] RAM_EN_KEY    = 8'h0A;
    localparam logic [7:0] RAM_DIS_KEY   = 8'h00;
    localparam logic [7:0] CLK_SEL_FIRST = 8'h08;
    localparam logic [7:0] CLK_SEL_END   = 8'h0D;

    typedef struct packed {
        logic [7:0]            cart_kind;
        logic [3:0]            rom_size_code;
        logic [RAM_SIZE_W-1:0] ram_size_bytes;
        logic                  rumble_enable;
    } cfg_t;

    typedef struct packed {
        logic [RAM_BANK_W-1:0] ram_bank;
        logic                  ram_enabled;
        logic [CLK_SEL_W-1:0]  clock_select;
        logic                  ram_banking_mode;
    } bank_state_t;

    typedef struct packed {
        logic clock_latch;
        logic rumble_valid;
        logic rumble_on;
    } pulse_t;

endpackage

// ----- rtl/core/cbc_write_if.sv -----
interface cbc_write_if;
    import cbc_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] write_addr;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output write_addr, output write_data, input ready);
    modport sink   (input valid, input write_addr, input write_data, output ready);
endinterface

// ----- rtl/core/cbc_map_if.sv -----
interface cbc_map_if;
    import cbc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ROM_BANK_W-1:0] rom_bank_out;
    logic [RAM_BANK_W-1:0] ram_bank_out;
    logic                  ram_enabled_out;
    logic [CLK_SEL_W-1:0]  clock_select_out;
    logic                  ram_banking_mode_out;
    logic                  clock_latch_pulse;
    logic                  rumble_valid;
    logic                  rumble_on;

    modport source (
        output valid, output rom_bank_out, output ram_bank_out, output ram_enabled_out,
        output clock_select_out, output ram_banking_mode_out, output clock_latch_pulse,
        output rumble_valid, output rumble_on, input ready
    );
    modport sink (
        input valid, input rom_bank_out, input ram_bank_out, input ram_enabled_out,
        input clock_select_out, input ram_banking_mode_out, input clock_latch_pulse,
        input rumble_valid, input rumble_on, output ready
    );
endinterface

// ----- rtl/core/cbc_cfg_regs.sv -----
module cbc_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  cbc_pkg::cfg_index_t            cfg_index,
    input  logic [cbc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output cbc_pkg::cfg_t                  cfg
);
    import cbc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_CART_KIND:     cfg_reg.cart_kind      <= cfg_wdata[7:0];
                CFG_ROM_SIZE_CODE: cfg_reg.rom_size_code  <= cfg_wdata[3:0];
                CFG_RAM_SIZE:      cfg_reg.ram_size_bytes <= cfg_wdata[RAM_SIZE_W-1:0];
                CFG_RUMBLE_EN:     cfg_reg.rumble_enable  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/cbc_update.sv -----
module cbc_update #(
    parameter int MAX_ROM_BANK_BITS = 9
) (
    input  cbc_pkg::cfg_t                  cfg,
    input  logic [MAX_ROM_BANK_BITS-1:0]   rom_bank,
    input  cbc_pkg::bank_state_t           state,
    input  logic [cbc_pkg::ADDR_W-1:0]     write_addr,
    input  logic [cbc_pkg::DATA_W-1:0]     write_data,
    output logic [MAX_ROM_BANK_BITS-1:0]   rom_bank_next,
    output cbc_pkg::bank_state_t           state_next,
    output cbc_pkg::pulse_t                pulse_next
);
    import cbc_pkg::*;

    typedef enum logic [2:0] {
        FAM_NONE,
        FAM_MBC1,
        FAM_MBC2,
        FAM_MBC3,
        FAM_MBC5
    } family_t;

    family_t               family;
    region_t               region;
    logic [ROM_BANK_W-1:0] wrap_mask;
    logic [ROM_BANK_W-1:0] rb;
    logic [ROM_BANK_W-1:0] b;
    logic [RAM_BANK_W-1:0] mbc5_bank;
    bank_state_t           st;
    pulse_t                p;

    // 0x2000 * bank < RAM size
    function automatic logic ram_fits(input logic [7:0] bank,
                                      input logic [RAM_SIZE_W-1:0] size);
        return {bank, 13'b0} < {3'b0, size};
    endfunction

    always_comb
    begin
        unique case (cfg.cart_kind) inside
            [KIND_MBC1_FIRST:KIND_MBC1_LAST]: family = FAM_MBC1;
            KIND_MBC2_A, KIND_MBC2_B:         family = FAM_MBC2;
            KIND_MBC3_A, KIND_MBC3_B:         family = FAM_MBC3;
            [KIND_MBC5_FIRST:KIND_MBC5_LAST]: family = FAM_MBC5;
            default:                          family = FAM_NONE;
        endcase
    end

    // Bank count is a power of two; codes of 8 and up cover every 9-bit bank.
    always_comb
    begin
        if (cfg.rom_size_code >= 4'd8)
            wrap_mask = '1;
        else
            wrap_mask = ROM_BANK_W'((10'd2 << cfg.rom_size_code[2:0]) - 10'd1);
    end

    assign region    = write_addr[14:13];
    assign rb        = ROM_BANK_W'(rom_bank);
    assign mbc5_bank = cfg.rumble_enable ? {1'b0, write_data[2:0]} : write_data[3:0];

    always_comb
    begin
        b  = rb;
        st = state;
        p  = '0;
        case (family)
            FAM_MBC1:
            begin
                case (region)
                    REGION_ROM_BANK:
                    begin
                        b = {1'b0, rb[7:5], write_data[4:0]} & wrap_mask;
                        if (b == '0)
                            b = ROM_BANK_W'(1);
                    end
                    REGION_RAM_BANK:
                    begin
                        if (!state.ram_banking_mode)
                            b = {1'b0, write_data[2:0], rb[4:0]} & wrap_mask;
                        else if (ram_fits(write_data, cfg.ram_size_bytes))
                            st.ram_bank = write_data[3:0];
                    end
                    REGION_MODE: st.ram_banking_mode = write_data[0];
                    default: ;
                endcase
            end
            FAM_MBC2:
            begin
                if (region == REGION_ROM_BANK)
                    b = {5'b0, write_data[3:0]};
            end
            FAM_MBC3:
            begin
                case (region)
                    REGION_RAM_EN:
                    begin
                        if (write_data == RAM_EN_KEY)
                            st.ram_enabled = 1'b1;
                        else if (write_data == RAM_DIS_KEY)
                            st.ram_enabled = 1'b0;
                    end
                    REGION_ROM_BANK:
                    begin
                        b = {2'b0, write_data[6:0]} & wrap_mask;
                        if (b == '0)
                            b = ROM_BANK_W'(1);
                    end
                    REGION_RAM_BANK:
                    begin
                        if (write_data < CLK_SEL_FIRST)
                        begin
                            st.clock_select = '0;
                            if (ram_fits({4'b0, write_data[3:0]}, cfg.ram_size_bytes))
                                st.ram_bank = write_data[3:0];
                        end
                        else if (write_data < CLK_SEL_END)
                        begin
                            st.clock_select = write_data[3:0];
                        end
                    end
                    default: p.clock_latch = 1'b1;
                endcase
            end
            FAM_MBC5:
            begin
                case (region)
                    REGION_RAM_EN:
                    begin
                        if (cfg.ram_size_bytes != '0)
                        begin
                            if (write_data == RAM_EN_KEY)
                                st.ram_enabled = 1'b1;
                            else if (write_data == RAM_DIS_KEY)
                                st.ram_enabled = 1'b0;
                        end
                    end
                    REGION_ROM_BANK:
                    begin
                        // 0x2000-0x2FFF low eight bits, 0x3000-0x3FFF bit eight
                        if (!write_addr[12])
                            b = {rb[8], write_data} & wrap_mask;
                        else
                            b = {write_data[0], rb[7:0]} & wrap_mask;
                    end
                    REGION_RAM_BANK:
                    begin
                        p.rumble_valid = cfg.rumble_enable;
                        p.rumble_on    = cfg.rumble_enable & write_data[3];
                        if (state.ram_enabled
                            && ram_fits({4'b0, mbc5_bank}, cfg.ram_size_bytes))
                            st.ram_bank = mbc5_bank;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign rom_bank_next = b[MAX_ROM_BANK_BITS-1:0];
    assign state_next    = st;
    assign pulse_next    = p;

endmodule

// ----- rtl/core/cartridge_bank_controller.sv -----
// Path: input register, then result register; a held result with bank_map.ready low
// blocks the move between them. Throughput: one write per cycle while no such stall
// holds; the mapping registers update in the cycle that moves an item into the result
// register, so back-to-back writes see each other.
// Reset: rst_n clears the configuration to zero, sets ROM bank to 1 and the RAM
// bank, RAM enable, clock select and banking mode to 0; no item is held.
module cartridge_bank_controller #(
    parameter int MAX_ROM_BANK_BITS = 9
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  cbc_pkg::cfg_index_t            cfg_index,
    input  logic [cbc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    cbc_write_if.sink                      cpu_wr,
    cbc_map_if.source                      bank_map
);
    import cbc_pkg::*;

    cfg_t                         cfg;

    logic                         s1_valid_reg;
    logic [ADDR_W-1:0]            s1_addr_reg;
    logic [DATA_W-1:0]            s1_data_reg;

    logic                         out_valid_reg;
    pulse_t                       pulse_reg;
    pulse_t                       pulse_next;

    logic [MAX_ROM_BANK_BITS-1:0] rom_bank_reg;
    logic [MAX_ROM_BANK_BITS-1:0] rom_bank_next;
    bank_state_t                  state_reg;
    bank_state_t                  state_next;

    logic                         out_load;
    logic                         in_fire;

    cbc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cbc_update #(
        .MAX_ROM_BANK_BITS (MAX_ROM_BANK_BITS)
    ) u_update (
        .cfg           (cfg),
        .rom_bank      (rom_bank_reg),
        .state         (state_reg),
        .write_addr    (s1_addr_reg),
        .write_data    (s1_data_reg),
        .rom_bank_next (rom_bank_next),
        .state_next    (state_next),
        .pulse_next    (pulse_next)
    );

    assign out_load     = s1_valid_reg && (!out_valid_reg || bank_map.ready);
    assign cpu_wr.ready = !s1_valid_reg || out_load;
    assign in_fire      = cpu_wr.valid && cpu_wr.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rom_bank_reg  <= MAX_ROM_BANK_BITS'(1);
            state_reg     <= '0;
        end
        else
        begin
            if (cpu_wr.ready)
                s1_valid_reg <= cpu_wr.valid;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                rom_bank_reg  <= rom_bank_next;
                state_reg     <= state_next;
            end
            else if (bank_map.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_addr_reg <= cpu_wr.write_addr;
            s1_data_reg <= cpu_wr.write_data;
        end
        if (out_load)
            pulse_reg <= pulse_next;
    end

    // Mapping state only changes on out_load, so it doubles as the result register.
    assign bank_map.valid                = out_valid_reg;
    assign bank_map.rom_bank_out         = ROM_BANK_W'(rom_bank_reg);
    assign bank_map.ram_bank_out         = state_reg.ram_bank;
    assign bank_map.ram_enabled_out      = state_reg.ram_enabled;
    assign bank_map.clock_select_out     = state_reg.clock_select;
    assign bank_map.ram_banking_mode_out = state_reg.ram_banking_mode;
    assign bank_map.clock_latch_pulse    = pulse_reg.clock_latch;
    assign bank_map.rumble_valid         = pulse_reg.rumble_valid;
    assign bank_map.rumble_on            = pulse_reg.rumble_on;

`ifndef SYNTH
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> cpu_wr.ready)
        else $error("input stalled while result register empty");

    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_load |=> s1_valid_reg)
        else $error("staged item dropped");

    a_pulse_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(pulse_reg.clock_latch && pulse_reg.rumble_valid)
                          && (pulse_reg.rumble_valid || !pulse_reg.rumble_on))
        else $error("inconsistent pulse flags");

    a_clock_select_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.clock_select == '0
        || (state_reg.clock_select >= 4'd8 && state_reg.clock_select <= 4'd12))
        else $error("clock select out of range");
`endif

endmodule
